### hw/rtl/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared codes and types of the fit-policy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

  // Operation codes carried in the input tuser field.
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_REINIT  = 2'd2;

  // Result status codes carried in the output tuser field.
  localparam logic [2:0] ST_REUSED    = 3'd0;
  localparam logic [2:0] ST_APPENDED  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DONE      = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX = 3'd4;

  // Search policy codes. Any other code searches as first fit.
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_FIT_POLICY   = 1'b0;
  localparam logic CFG_INITIAL_SIZE = 1'b1;

  // Fixed field widths of the stream payloads.
  localparam int FIELD_SIZE_W  = 16;
  localparam int FIELD_INDEX_W = 4;

  // Control from the sequencer to the compare unit.
  typedef struct packed {
    logic start;  // clear the running pick at the start of a search
    logic vld;    // candidate entry on the compare inputs this cycle
  } scan_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/fpba_ram.sv
// ----------------------------------------------------------------------------
// fpba_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One access per cycle: a registered read, with a write as well when we is high; the read then returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

`default_nettype wire

### hw/rtl/fpba_scan.sv
// ----------------------------------------------------------------------------
// fpba_scan
// Compare unit of the allocator: checks one table entry per cycle against the
// request and keeps the best pick so far under the selected policy.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_scan #(
  parameter int IDX_W     = 4,
  parameter int SIZE_BITS = 16
) (
  input  wire logic                     clk,
  input  wire fpba_pkg::scan_ctl_t      ctl,
  input  wire logic [1:0]               policy,
  input  wire logic [SIZE_BITS-1:0]     want,
  input  wire logic [IDX_W-1:0]         cand_idx,
  input  wire logic [SIZE_BITS-1:0]     cand_size,
  input  wire logic                     cand_free,
  output logic                          found_r,
  output logic      [IDX_W-1:0]         pick_idx_r,
  output logic      [SIZE_BITS-1:0]     pick_size_r
);

  logic fits;
  logic better;

  // A candidate qualifies when it is free and large enough. It replaces the
  // current pick only on a strict improvement, so ties keep the earliest.
  always_comb begin
    fits   = cand_free && (cand_size >= want);
    better = !found_r
          || ((policy == fpba_pkg::POL_BEST)  && (cand_size < pick_size_r))
          || ((policy == fpba_pkg::POL_WORST) && (cand_size > pick_size_r));
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      found_r <= 1'b0;
    end else if (ctl.vld && fits && better) begin
      found_r     <= 1'b1;
      pick_idx_r  <= cand_idx;
      pick_size_r <= cand_size;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fit_policy_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit
// Block table with first, best and worst fit allocation, release and reload.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one transaction is one operation. in_tuser holds the
//   mode (allocate, release, reinitialize); in_tdata holds the request size
//   and the block index. Output stream (out_*): exactly one result per
//   operation, status in out_tuser, granted index and size in out_tdata.
//   Configuration (cfg_*): always ready; write the fit policy and initial
//   size only while no operation is in flight.
//   Sequence: an allocate on a non-empty table issues one RAM read per entry
//   in S_SCAN, compares the last entry, leaves the scan and then commits in
//   S_FINISH. An allocate on an empty table, a release, a reinitialize and an
//   unknown mode go from acceptance straight to the commit. A new operation
//   is accepted in the cycle after the result is loaded into the output
//   register.
//   Reset: rst_n low empties the table, clears all free marks and resets
//   both configuration registers to zero. No clearing pass is needed.
//   Stall: a result waits in the output register while out_tready is low; a
//   following operation may run meanwhile and then holds its commit until
//   the register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fit_policy_block_allocator_unit #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // request_size[15:0], block_index[19:16], zero pad
  input  wire logic [1:0]  in_tuser,   // mode[1:0]
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // granted_index[3:0], granted_size[19:4], zero pad
  output logic      [2:0]  out_tuser,  // status[2:0]
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int FS_W  = fpba_pkg::FIELD_SIZE_W;
  localparam int FI_W  = fpba_pkg::FIELD_INDEX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t               state_r;
  logic [1:0]           policy_r;
  logic [SIZE_BITS-1:0] init_size_r;
  logic [CNT_W-1:0]     used_r;
  logic [MAX_BLOCKS-1:0] free_r;

  logic [1:0]           op_mode_r;
  logic [SIZE_BITS-1:0] op_want_r;
  logic [FI_W-1:0]      op_idx_r;

  logic [IDX_W-1:0]     issue_idx_r;
  logic                 issue_on_r;
  logic                 cmp_vld_r;
  logic [IDX_W-1:0]     cmp_idx_r;

  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [FI_W-1:0]      out_idx_r;
  logic [FS_W-1:0]      out_size_r;

  logic                 in_acc;
  logic                 out_free;
  logic                 commit;
  logic [SIZE_BITS+FS_W-1:0] want_ext;
  logic [SIZE_BITS+FS_W-1:0] cfg_size_ext;
  logic [SIZE_BITS+FS_W-1:0] pick_size_ext;
  logic [SIZE_BITS+FS_W-1:0] want_out_ext;
  logic [IDX_W+FI_W-1:0]     pick_idx_ext;
  logic [IDX_W+FI_W-1:0]     used_idx_ext;
  logic [CNT_W+FI_W-1:0]     rel_idx_ext;
  logic [CNT_W+FI_W-1:0]     used_cmp_ext;
  logic                 rel_ok;
  logic [IDX_W-1:0]     rel_slot;
  logic                 has_room;
  logic                 last_issue;
  logic [IDX_W-1:0]     used_slot;

  logic [2:0]           res_status;
  logic [FI_W-1:0]      res_idx;
  logic [FS_W-1:0]      res_size;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_addr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [SIZE_BITS-1:0] ram_rdata;

  fpba_pkg::scan_ctl_t  scan_ctl;
  logic                 found;
  logic [IDX_W-1:0]     pick_idx;
  logic [SIZE_BITS-1:0] pick_size;

  // Handshakes and width adaptation of the fixed-width fields.
  always_comb begin
    in_tready     = (state_r == S_IDLE);
    cfg_ready     = 1'b1;
    in_acc        = in_tvalid && in_tready;
    out_free      = !out_valid_r || out_tready;
    commit        = (state_r == S_FINISH) && out_free;
    want_ext      = {{SIZE_BITS{1'b0}}, in_tdata[FS_W-1:0]};
    cfg_size_ext  = {{SIZE_BITS{1'b0}}, cfg_data};
    pick_size_ext = {{FS_W{1'b0}}, pick_size};
    want_out_ext  = {{FS_W{1'b0}}, op_want_r};
    pick_idx_ext  = {{FI_W{1'b0}}, pick_idx};
    used_slot     = used_r[IDX_W-1:0];
    used_idx_ext  = {{FI_W{1'b0}}, used_slot};
    rel_idx_ext   = {{CNT_W{1'b0}}, op_idx_r};
    used_cmp_ext  = {{FI_W{1'b0}}, used_r};
    rel_ok        = rel_idx_ext < used_cmp_ext;
    rel_slot      = rel_idx_ext[IDX_W-1:0];
    has_room      = used_r < CNT_W'(MAX_BLOCKS);
    last_issue    = CNT_W'(issue_idx_r) == (used_r - CNT_W'(1));
  end

  // Result fields of the operation that is being committed.
  always_comb begin
    res_status = fpba_pkg::ST_DONE;
    res_idx    = '0;
    res_size   = '0;
    case (op_mode_r)
      fpba_pkg::MODE_ALLOC: begin
        if (found) begin
          res_status = fpba_pkg::ST_REUSED;
          res_idx    = pick_idx_ext[FI_W-1:0];
          res_size   = pick_size_ext[FS_W-1:0];
        end else if (has_room) begin
          res_status = fpba_pkg::ST_APPENDED;
          res_idx    = used_idx_ext[FI_W-1:0];
          res_size   = want_out_ext[FS_W-1:0];
        end else begin
          res_status = fpba_pkg::ST_FULL;
        end
      end
      fpba_pkg::MODE_RELEASE: begin
        if (!rel_ok) begin
          res_status = fpba_pkg::ST_BAD_INDEX;
        end
      end
      default: ;
    endcase
  end

  // RAM port: scan reads, or the append and reload writes at commit.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = issue_idx_r;
    ram_wdata = op_want_r;
    if (commit) begin
      if ((op_mode_r == fpba_pkg::MODE_ALLOC) && !found && has_room) begin
        ram_we   = 1'b1;
        ram_addr = used_slot;
      end else if (op_mode_r == fpba_pkg::MODE_REINIT) begin
        ram_we    = 1'b1;
        ram_addr  = '0;
        ram_wdata = init_size_r;
      end
    end
  end

  fpba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_sizes (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Compare unit sees the entry read in the previous cycle.
  always_comb begin
    scan_ctl.start = in_acc;
    scan_ctl.vld   = cmp_vld_r;
  end

  fpba_scan #(
    .IDX_W     (IDX_W),
    .SIZE_BITS (SIZE_BITS)
  ) u_scan (
    .clk         (clk),
    .ctl         (scan_ctl),
    .policy      (policy_r),
    .want        (op_want_r),
    .cand_idx    (cmp_idx_r),
    .cand_size   (ram_rdata),
    .cand_free   (free_r[cmp_idx_r]),
    .found_r     (found),
    .pick_idx_r  (pick_idx),
    .pick_size_r (pick_size)
  );

  // Sequencer, table state, configuration and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= fpba_pkg::POL_FIRST;
      init_size_r <= '0;
      used_r      <= '0;
      free_r      <= '0;
      issue_on_r  <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fpba_pkg::CFG_FIT_POLICY:   policy_r    <= cfg_data[1:0];
          fpba_pkg::CFG_INITIAL_SIZE: init_size_r <= cfg_size_ext[SIZE_BITS-1:0];
          default: ;
        endcase
      end

      // A taken result empties the register unless a new one loads it.
      if (out_valid_r && out_tready && !commit) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            issue_idx_r <= '0;
            if ((in_tuser == fpba_pkg::MODE_ALLOC) && (used_r != '0)) begin
              issue_on_r <= 1'b1;
              state_r    <= S_SCAN;
            end else begin
              state_r <= S_FINISH;
            end
          end
        end

        // One entry issued to the RAM per cycle; the compare follows on the registered read data and index.
        S_SCAN: begin
          cmp_vld_r <= issue_on_r;
          cmp_idx_r <= issue_idx_r;
          if (issue_on_r) begin
            if (last_issue) begin
              issue_on_r <= 1'b0;
            end else begin
              issue_idx_r <= issue_idx_r + IDX_W'(1);
            end
          end else if (!cmp_vld_r) begin
            state_r <= S_FINISH;
          end
        end

        // Apply the operation and load its result.
        S_FINISH: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status;
            out_idx_r    <= res_idx;
            out_size_r   <= res_size;
            state_r      <= S_IDLE;
            case (op_mode_r)
              fpba_pkg::MODE_ALLOC: begin
                if (found) begin
                  free_r[pick_idx] <= 1'b0;
                end else if (has_room) begin
                  free_r[used_slot] <= 1'b0;
                  used_r            <= used_r + CNT_W'(1);
                end
              end
              fpba_pkg::MODE_RELEASE: begin
                if (rel_ok) begin
                  free_r[rel_slot] <= 1'b1;
                end
              end
              fpba_pkg::MODE_REINIT: begin
                free_r[0] <= 1'b1;
                used_r    <= CNT_W'(1);
              end
              default: ;
            endcase
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Operation fields held for the length of the operation.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_mode_r <= in_tuser;
      op_want_r <= want_ext[SIZE_BITS-1:0];
      op_idx_r  <= in_tdata[FS_W+FI_W-1:FS_W];
    end
  end

  // Output stream packing.
  always_comb begin
    out_tvalid = out_valid_r;
    out_tuser  = out_status_r;
    out_tdata  = {4'b0, out_size_r, out_idx_r};
  end

endmodule

`default_nettype wire

### bench/fit_policy_block_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit_tb
// Self-checking bench for the fit-policy block allocator.
// ----------------------------------------------------------------------------
// A queue of operations feeds a stream driver. Every accepted transaction is
// run through a local model of the block table, and the predicted grant is
// queued. A monitor compares each result transaction field by field with the
// oldest predicted grant. The run starts with a short directed sequence that
// covers the corner cases. Eight random phases follow, with every fit policy
// and several initial sizes, under different amounts of source idling and
// sink back-pressure.
// ----------------------------------------------------------------------------

module fit_policy_block_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam realtime CLK_PERIOD       = 4.0;
  localparam int      TABLE_DEPTH      = 16;
  localparam int      WATCHDOG_LIMIT   = 2000;
  localparam int      SETTLE_CYCLES    = 24;
  localparam int      OPS_PER_PHASE    = 150;
  localparam int      PHASE_COUNT      = 8;
  localparam int      MAX_PRINTED      = 40;

  // Codes that the package leaves unnamed but the block must still handle.
  localparam logic [1:0] MODE_UNKNOWN = 2'd3;
  localparam logic [1:0] POL_UNKNOWN  = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] req_size;
    logic [3:0]  blk_index;
  } alloc_op_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  grant_index;
    logic [15:0] grant_size;
  } grant_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = 1'b0;
  logic [15:0] cfg_data   = '0;

  // Model of the block table and its configuration.
  logic [15:0] tbl_size [TABLE_DEPTH];
  logic        tbl_free [TABLE_DEPTH] = '{default: 1'b0};
  int unsigned tbl_used       = 0;
  logic [1:0]  cur_policy     = fpba_pkg::POL_FIRST;
  logic [15:0] cur_init_size  = '0;

  alloc_op_t   pending_ops[$];
  alloc_op_t   op_on_bus;
  grant_t      expected_grants[$];
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned ops_accepted   = 0;
  int unsigned grants_checked = 0;
  int unsigned status_count [5] = '{default: 0};
  int unsigned error_count    = 0;
  int unsigned quiet_cycles   = 0;

  fit_policy_block_allocator_unit #(
    .MAX_BLOCKS(TABLE_DEPTH),
    .SIZE_BITS (16)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Applies one operation to the table model and returns the grant it causes.
  function automatic grant_t compute_grant(alloc_op_t op);
    grant_t      g;
    int unsigned pick;
    bit          found;
    g = '{status: fpba_pkg::ST_DONE, grant_index: '0, grant_size: '0};
    case (op.mode)
      fpba_pkg::MODE_ALLOC: begin
        found = 1'b0;
        pick  = 0;
        // First fit keeps the earliest hit; best and worst replace it only
        // on a strictly better size, so ties stay with the earliest entry.
        for (int i = 0; i < tbl_used; i++) begin
          if (tbl_free[i] && tbl_size[i] >= op.req_size) begin
            if (!found) begin
              pick  = i;
              found = 1'b1;
            end else if (cur_policy == fpba_pkg::POL_BEST &&
                         tbl_size[i] < tbl_size[pick]) begin
              pick = i;
            end else if (cur_policy == fpba_pkg::POL_WORST &&
                         tbl_size[i] > tbl_size[pick]) begin
              pick = i;
            end
          end
        end
        if (found) begin
          tbl_free[pick] = 1'b0;
          g.status      = fpba_pkg::ST_REUSED;
          g.grant_index = pick[3:0];
          g.grant_size  = tbl_size[pick];
        end else if (tbl_used < TABLE_DEPTH) begin
          tbl_size[tbl_used] = op.req_size;
          tbl_free[tbl_used] = 1'b0;
          g.status      = fpba_pkg::ST_APPENDED;
          g.grant_index = tbl_used[3:0];
          g.grant_size  = op.req_size;
          tbl_used++;
        end else begin
          g.status = fpba_pkg::ST_FULL;
        end
      end
      fpba_pkg::MODE_RELEASE: begin
        if (op.blk_index < tbl_used) begin
          tbl_free[op.blk_index] = 1'b1;
        end else begin
          g.status = fpba_pkg::ST_BAD_INDEX;
        end
      end
      fpba_pkg::MODE_REINIT: begin
        tbl_size[0] = cur_init_size;
        tbl_free[0] = 1'b1;
        tbl_used    = 1;
      end
      default: begin
      end
    endcase
    return g;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned exp_val,
                                 input int unsigned got_val);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("%0t ns: MISMATCH %s: expected 0x%0h, got 0x%0h", $realtime, what,
               exp_val, got_val);
    end
  endtask

  // Source side: presents queued operations and predicts each accepted one.
  always @(posedge clk) begin : drive_ops
    alloc_op_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_grants.push_back(compute_grant(op_on_bus));
        ops_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt       = pending_ops.pop_front();
          op_on_bus = nxt;
          in_tvalid <= 1'b1;
          in_tdata  <= {4'b0000, nxt.blk_index, nxt.req_size};
          in_tuser  <= nxt.mode;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: random back-pressure and field-by-field result checking.
  always @(posedge clk) begin : check_grants
    grant_t got;
    grant_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status      = out_tuser;
        got.grant_index = out_tdata[3:0];
        got.grant_size  = out_tdata[19:4];
        grants_checked++;
        if (got.status <= fpba_pkg::ST_BAD_INDEX) begin
          status_count[got.status]++;
        end
        if (expected_grants.size() == 0) begin
          report_mismatch("result transaction with nothing expected", 0, 32'(got));
        end else begin
          want = expected_grants.pop_front();
          if (got.status != want.status) begin
            report_mismatch("status", 32'(want.status), 32'(got.status));
          end
          if (got.grant_index != want.grant_index) begin
            report_mismatch("granted_index", 32'(want.grant_index),
                            32'(got.grant_index));
          end
          if (got.grant_size != want.grant_size) begin
            report_mismatch("granted_size", 32'(want.grant_size),
                            32'(got.grant_size));
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Ends the run when no transaction of any kind completes for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results still expected",
               quiet_cycles, expected_grants.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_register(input logic idx, input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == fpba_pkg::CFG_FIT_POLICY) begin
      cur_policy = value[1:0];
    end else begin
      cur_init_size = value;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_op(input logic [1:0] mode, input logic [15:0] sz,
                          input logic [3:0] idx);
    pending_ops.push_back('{mode: mode, req_size: sz, blk_index: idx});
  endtask

  // Waits until every queued operation has been sent and answered.
  task automatic wait_drained;
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_tvalid || expected_grants.size() != 0);
  endtask

  // Request sizes lean toward small values so that fits and ties are common.
  function automatic logic [15:0] pick_request_size();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(40));
    endcase
  endfunction

  initial begin
    logic [1:0]  policy_seq [4];
    logic [15:0] init_seq   [4];
    logic [1:0]  mode;
    logic [3:0]  idx;
    int          issued;
    int          seq_len;
    int          r;

    policy_seq = '{fpba_pkg::POL_FIRST, fpba_pkg::POL_BEST, fpba_pkg::POL_WORST,
                   POL_UNKNOWN};
    init_seq   = '{16'h0000, 16'hFFFF, 16'd30, 16'($urandom_range(65535))};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sequence: empty table, bad indexes, unknown mode, reload,
    // double release, reuse, filling the table and allocating when full.
    write_register(fpba_pkg::CFG_FIT_POLICY, 16'(fpba_pkg::POL_FIRST));
    write_register(fpba_pkg::CFG_INITIAL_SIZE, 16'd100);
    queue_op(fpba_pkg::MODE_ALLOC, 16'd5, 4'd0);
    queue_op(fpba_pkg::MODE_RELEASE, 16'hFFFF, 4'd15);
    queue_op(fpba_pkg::MODE_RELEASE, 16'd0, 4'd1);
    queue_op(MODE_UNKNOWN, 16'hFFFF, 4'hF);
    queue_op(fpba_pkg::MODE_REINIT, 16'd0, 4'd0);
    queue_op(fpba_pkg::MODE_ALLOC, 16'hFFFF, 4'd0);
    queue_op(fpba_pkg::MODE_RELEASE, 16'd0, 4'd0);
    queue_op(fpba_pkg::MODE_RELEASE, 16'd0, 4'd0);
    queue_op(fpba_pkg::MODE_ALLOC, 16'd0, 4'd0);
    for (int i = 0; i < TABLE_DEPTH - 2; i++) begin
      queue_op(fpba_pkg::MODE_ALLOC, 16'(i * 3 + 1), 4'(i));
    end
    queue_op(fpba_pkg::MODE_ALLOC, 16'd1, 4'd0);
    queue_op(fpba_pkg::MODE_RELEASE, 16'd0, 4'd15);
    wait_drained();

    // Random phases: each mostly starts well-formed runs from a reload.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase / 2)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      write_register(fpba_pkg::CFG_FIT_POLICY, 16'(policy_seq[phase % 4]));
      write_register(fpba_pkg::CFG_INITIAL_SIZE, init_seq[(phase / 2) % 4]);
      issued = 0;
      while (issued < OPS_PER_PHASE) begin
        if ($urandom_range(9) < 8) begin
          queue_op(fpba_pkg::MODE_REINIT, 16'($urandom_range(65535)),
                   4'($urandom_range(15)));
          issued++;
        end
        seq_len = $urandom_range(4, 50);
        repeat (seq_len) begin
          r = $urandom_range(99);
          if (r < 60) begin
            mode = fpba_pkg::MODE_ALLOC;
          end else if (r < 90) begin
            mode = fpba_pkg::MODE_RELEASE;
          end else if (r < 95) begin
            mode = MODE_UNKNOWN;
          end else begin
            mode = fpba_pkg::MODE_REINIT;
          end
          idx = ($urandom_range(9) < 6) ? 4'($urandom_range(7)) : 4'($urandom_range(15));
          queue_op(mode, pick_request_size(), idx);
          issued++;
        end
      end
      wait_drained();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_grants.size() != 0) begin
      report_mismatch("results never delivered", 32'(expected_grants.size()), 0);
    end

    $display("Sent %0d operations (directed, then %0d random phases over all policies);",
             ops_accepted, PHASE_COUNT);
    $display("checked %0d results: reused %0d, appended %0d, full %0d, done %0d, bad %0d.",
             grants_checked, status_count[fpba_pkg::ST_REUSED],
             status_count[fpba_pkg::ST_APPENDED], status_count[fpba_pkg::ST_FULL],
             status_count[fpba_pkg::ST_DONE], status_count[fpba_pkg::ST_BAD_INDEX]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
